/* hdl/mcr_pkg.sv */
// Package for the midpoint circle rasterizer: sizes, function codes and the
// step record passed from the front end to the point sequencer.
// No dependencies.
package mcr_pkg;

   localparam int RADIUS_BITS   = 11;
   localparam int COORD_BITS    = 12;
   localparam int DECISION_BITS = RADIUS_BITS + 5;
   localparam int POINT_BITS    = 14;
   localparam int OCTANT_BITS   = 3;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // function codes carried in the request word
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam logic [OCTANT_BITS-1:0] LAST_OCTANT = '1;

   // one step: the centre, the offsets before the update, and the end flag
   typedef struct packed {
      logic [COORD_BITS-1:0]  origin_x;
      logic [COORD_BITS-1:0]  origin_y;
      logic [RADIUS_BITS-1:0] offset_x;
      logic [RADIUS_BITS-1:0] offset_y;
      logic                   done;
   } step_job_type;

   // status from the queue to the front end and the point sequencer
   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

endpackage

/* hdl/mcr_intf.sv */
// Channel interfaces for the midpoint circle rasterizer: request and
// response words with valid/ready. Depends on mcr_pkg.
interface mcr_req_intf;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [mcr_pkg::COORD_BITS-1:0] center_x;
   logic [mcr_pkg::COORD_BITS-1:0] center_y;
   logic [mcr_pkg::RADIUS_BITS-1:0] radius;

   modport source (output valid, func, center_x, center_y, radius, input ready);
   modport sink   (input valid, func, center_x, center_y, radius, output ready);
endinterface

interface mcr_rsp_intf;
   logic                                  valid;
   logic                                  ready;
   logic signed [mcr_pkg::POINT_BITS-1:0] point_x;
   logic signed [mcr_pkg::POINT_BITS-1:0] point_y;
   logic [mcr_pkg::OCTANT_BITS-1:0]       octant;
   logic                                  last_of_step;
   logic                                  circle_done;

   modport source (output valid, point_x, point_y, octant, last_of_step, circle_done,
                   input ready);
   modport sink   (input valid, point_x, point_y, octant, last_of_step, circle_done,
                   output ready);
endinterface

/* hdl/mcr_front.sv */
// Front end: accepts request words, holds the circle state and runs the
// midpoint update, one step per word. Depends on mcr_pkg and mcr_req_intf.
module mcr_front (
   input  logic                  clock,
   input  logic                  reset,
   mcr_req_intf.sink             req,
   input  mcr_pkg::queue_status_type q_status,
   output logic                  push_valid,
   output mcr_pkg::step_job_type push_job
);

   localparam int RB = mcr_pkg::RADIUS_BITS;
   localparam int DB = mcr_pkg::DECISION_BITS;

   logic [mcr_pkg::COORD_BITS-1:0] origin_x_ff, origin_y_ff;
   logic [RB-1:0]                  offset_x_ff, offset_y_ff;
   logic [DB-1:0]                  decision_ff;
   logic                           active_ff;

   logic          accept;
   logic          do_step;
   logic          dec_y;
   logic [RB:0]   x_next;
   logic [RB:0]   y_next;
   logic          done;
   logic [DB-1:0] x_ext, y_ext;
   logic [DB-1:0] decision_in;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign do_step   = accept && (req.func == mcr_pkg::FUNC_STEP) && active_ff;

   always_comb begin
      x_ext  = DB'(offset_x_ff);
      y_ext  = DB'(offset_y_ff);
      dec_y  = !decision_ff[DB-1];
      x_next = {1'b0, offset_x_ff} + (RB+1)'(1);
      y_next = {1'b0, offset_y_ff} - (RB+1)'(dec_y);
      // y may go below zero only on a zero radius; that always ends the circle
      done   = y_next[RB] || (x_next > y_next);
      if (dec_y) begin
         decision_in = decision_ff + ((x_ext - y_ext) << 2) + DB'(10);
      end else begin
         decision_in = decision_ff + (x_ext << 2) + DB'(6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else if (accept && req.func == mcr_pkg::FUNC_START) begin
         origin_x_ff <= req.center_x;
         origin_y_ff <= req.center_y;
         offset_x_ff <= '0;
         offset_y_ff <= req.radius;
         decision_ff <= DB'(3) - (DB'(req.radius) << 1);
         active_ff   <= 1'b1;
      end else if (do_step) begin
         offset_x_ff <= x_next[RB-1:0];
         offset_y_ff <= y_next[RB-1:0];
         decision_ff <= decision_in;
         active_ff   <= !done;
      end
   end

   assign push_valid        = do_step;
   assign push_job.origin_x = origin_x_ff;
   assign push_job.origin_y = origin_y_ff;
   assign push_job.offset_x = offset_x_ff;
   assign push_job.offset_y = offset_y_ff;
   assign push_job.done     = done;

endmodule

/* hdl/mcr_queue.sv */
// Short step queue between the front end and the point sequencer.
// Depends on mcr_pkg.
module mcr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  mcr_pkg::step_job_type     push_job,
   input  logic                      pop,
   output mcr_pkg::queue_status_type q_status,
   output mcr_pkg::step_job_type     head_job
);

   localparam int DEPTH = mcr_pkg::QUEUE_DEPTH;
   localparam int PB    = mcr_pkg::QUEUE_PTR_BITS;
   localparam int CB    = mcr_pkg::QUEUE_CNT_BITS;

   mcr_pkg::step_job_type entry_ff [DEPTH];
   logic [PB-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0] count_ff;

   function automatic logic [PB-1:0] next_ptr(input logic [PB-1:0] ptr);
      if (ptr == PB'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PB'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         count_ff <= count_ff + CB'(push_valid) - CB'(pop);
      end
   end

   assign head_job            = entry_ff[rd_ptr_ff];
   assign q_status.head_valid = (count_ff != '0);
   assign q_status.full       = (count_ff == CB'(DEPTH));

endmodule

/* hdl/mcr_back.sv */
// Point sequencer: walks the eight mirror images of the step at the queue
// head into the response register. Depends on mcr_pkg and mcr_rsp_intf.
module mcr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mcr_pkg::queue_status_type q_status,
   input  mcr_pkg::step_job_type     head_job,
   output logic                      pop,
   mcr_rsp_intf.source               rsp
);

   localparam int PW = mcr_pkg::POINT_BITS;
   localparam int OB = mcr_pkg::OCTANT_BITS;

   logic [OB-1:0]        octant_ff;
   logic                 rsp_valid_ff;
   logic signed [PW-1:0] point_x_ff, point_y_ff;
   logic [OB-1:0]        rsp_octant_ff;
   logic                 last_ff, done_ff;

   logic          load;
   logic [PW-1:0] off_a, off_b;
   logic [PW-1:0] point_x_in, point_y_in;

   assign load = q_status.head_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && (octant_ff == mcr_pkg::LAST_OCTANT);

   always_comb begin
      // octants 4..7 swap the roles of x and y
      off_a = octant_ff[2] ? PW'(head_job.offset_y) : PW'(head_job.offset_x);
      off_b = octant_ff[2] ? PW'(head_job.offset_x) : PW'(head_job.offset_y);
      point_x_in = octant_ff[0] ? PW'(head_job.origin_x) - off_a
                                : PW'(head_job.origin_x) + off_a;
      point_y_in = octant_ff[1] ? PW'(head_job.origin_y) - off_b
                                : PW'(head_job.origin_y) + off_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octant_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            octant_ff    <= octant_ff + OB'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_x_ff    <= point_x_in;
         point_y_ff    <= point_y_in;
         rsp_octant_ff <= octant_ff;
         last_ff       <= (octant_ff == mcr_pkg::LAST_OCTANT);
         done_ff       <= head_job.done;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.point_x      = point_x_ff;
   assign rsp.point_y      = point_y_ff;
   assign rsp.octant       = rsp_octant_ff;
   assign rsp.last_of_step = last_ff;
   assign rsp.circle_done  = done_ff;

   // a step stays at the queue head until its eighth point is loaded into the response register
   a_job_held: assert property (@(posedge clock) disable iff (reset)
      load && (octant_ff != mcr_pkg::LAST_OCTANT) |=> q_status.head_valid)
      else $error("step left the queue before its eighth point");

   // points of one step leave without gaps once the sink takes them
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.ready && !last_ff |=> rsp_valid_ff)
      else $error("gap inside the points of a step");

   // the last-point flag matches the octant it was loaded with
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (rsp_octant_ff == mcr_pkg::LAST_OCTANT)))
      else $error("last_of_step does not match octant");

endmodule

/* hdl/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer, top level: front end, step queue and point
// sequencer. Depends on mcr_pkg, mcr_intf, mcr_front, mcr_queue, mcr_back.
//
// A start word (func = 0) loads the centre and radius and returns nothing; each
// step word (func = 1) while a circle is running returns eight points, one for
// each mirror image in octant order, with last_of_step on octant 7 and
// circle_done on every point of the final step. A step with no running circle
// is taken and dropped, and a start abandons any running circle (points already
// queued still go out). The front end takes one word a cycle while the queue is not
// full and does the decision update in that cycle; a two-deep step queue then feeds
// the point sequencer, which writes one point a cycle into the response register
// while the response side takes them. The sustained step rate is set by the single
// response port, which carries eight points per step; start words and idle steps
// put nothing in the queue and never wait on the response side unless the queue is
// full. When the path is empty, a step word is written into the queue when it is
// taken, and its first point then goes from the queue head into the response register.
module midpoint_circle_rasterizer (
   input  logic         clock,
   input  logic         reset,
   mcr_req_intf.sink    req_if,
   mcr_rsp_intf.source  rsp_if
);

   logic                      push_valid;
   mcr_pkg::step_job_type     push_job;
   mcr_pkg::step_job_type     head_job;
   mcr_pkg::queue_status_type q_status;
   logic                      pop;

   // classify words, hold circle state, advance the decision value
   mcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // decouple the update from point output
   mcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .q_status   (q_status),
      .head_job   (head_job)
   );

   // expand each step into its eight mirrored points
   mcr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule

/* dv/testbench.sv */
// Testbench for midpoint_circle_rasterizer. It drives start and step words, predicts the
// eight mirrored points of every step, and checks each response word in order.
// Depends on mcr_pkg, the mcr_intf channel interfaces and the rasterizer RTL.
`timescale 1ns / 100ps

module testbench;
   import mcr_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   localparam int TOTAL_WORDS  = 270;
   // The response path is the step queue and then the response register, so this drain is generous.
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_CAP    = 40;

   // Circle predictor and point store. Every accepted request word goes in
   // through note_word. Every accepted response word is checked against the
   // oldest expected point in check_point.
   class circle_point_scoreboard;
      typedef struct {
         logic signed [POINT_BITS-1:0] px;
         logic signed [POINT_BITS-1:0] py;
         logic [OCTANT_BITS-1:0]       oct;
         logic                         last;
         logic                         done;
      } point_word_t;

      point_word_t                     expected_points[$];
      int                              mismatch_count;
      logic [COORD_BITS-1:0]           centre_x;
      logic [COORD_BITS-1:0]           centre_y;
      logic [RADIUS_BITS-1:0]          offset_x;
      logic [RADIUS_BITS-1:0]          offset_y;
      logic signed [DECISION_BITS-1:0] decision;
      bit                              running;

      function new();
         mismatch_count = 0;
         centre_x       = '0;
         centre_y       = '0;
         offset_x       = '0;
         offset_y       = '0;
         decision       = '0;
         running        = 1'b0;
      endfunction

      task flag_mismatch(string msg);
         if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
         mismatch_count++;
      endtask

      // Return 1 when the word changes anything. A step with no circle running
      // is dropped and returns 0.
      function bit note_word(logic func, logic [COORD_BITS-1:0] cx,
                             logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
         int          x, y, d, nx, ny, nd, u, v;
         bit          fin;
         point_word_t pw;
         if (func == FUNC_START) begin
            centre_x = cx;
            centre_y = cy;
            offset_x = '0;
            offset_y = r;
            decision = DECISION_BITS'(3 - 2 * int'(r));
            running  = 1'b1;
            return 1'b1;
         end
         if (!running)
            return 1'b0;
         x = offset_x;
         y = offset_y;
         d = decision;
         if (d < 0) begin
            nd = d + 4 * x + 6;
            ny = y;
         end else begin
            nd = d + 4 * (x - y) + 10;
            ny = y - 1;
         end
         nx  = x + 1;
         fin = (nx > ny);
         // Points use the offsets from before the update. Octants 4 to 7 swap x and y.
         for (int k = 0; k < 8; k++) begin
            u       = (k < 4) ? x : y;
            v       = (k < 4) ? y : x;
            pw.px   = POINT_BITS'(int'(centre_x) + (k[0] ? -u : u));
            pw.py   = POINT_BITS'(int'(centre_y) + (k[1] ? -v : v));
            pw.oct  = OCTANT_BITS'(k);
            pw.last = (pw.oct == LAST_OCTANT);
            pw.done = fin;
            expected_points.push_back(pw);
         end
         offset_x = RADIUS_BITS'(nx);
         offset_y = RADIUS_BITS'(ny);
         decision = DECISION_BITS'(nd);
         if (fin)
            running = 1'b0;
         return 1'b1;
      endfunction

      task check_point(logic signed [POINT_BITS-1:0] px, logic signed [POINT_BITS-1:0] py,
                       logic [OCTANT_BITS-1:0] oct, logic last, logic done);
         point_word_t pw;
         if (expected_points.size() == 0) begin
            flag_mismatch($sformatf("point (%0d,%0d) oct %0d with nothing expected",
                                    px, py, oct));
            return;
         end
         pw = expected_points.pop_front();
         if (px !== pw.px || py !== pw.py || oct !== pw.oct || last !== pw.last ||
             done !== pw.done)
            flag_mismatch($sformatf(
               "got (%0d,%0d) oct %0d last %b done %b, expected (%0d,%0d) oct %0d last %b done %b",
               px, py, oct, last, done, pw.px, pw.py, pw.oct, pw.last, pw.done));
      endtask
   endclass

   logic clock;
   logic reset;
   int   sender_idle_pct   = 31;
   int   receiver_idle_pct = 65;
   int   useful_words      = 0;
   int   cycle_count       = 0;

   circle_point_scoreboard sb = new();

   mcr_req_intf req_if ();
   mcr_rsp_intf rsp_if ();

   midpoint_circle_rasterizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Give up if the run hangs. Nothing comes after the finish.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[%0t] cycle limit reached with %0d points outstanding", $time,
               sb.expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response side: throttle ready at random at each falling edge, and sample
   // at the rising edge.
   initial begin
      rsp_if.ready = 1'b0;
      forever @(negedge clock) rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_point(rsp_if.point_x, rsp_if.point_y, rsp_if.octant,
                        rsp_if.last_of_step, rsp_if.circle_done);
   end

   // Present one request word and hold it until it is taken. Enter just after
   // a rising edge. Lower valid only for a gap, so that a word sent straight
   // after another keeps valid high with no second assignment in that step.
   task automatic send_word(logic func, logic [COORD_BITS-1:0] cx,
                            logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.func     <= func;
      req_if.center_x <= cx;
      req_if.center_y <= cy;
      req_if.radius   <= r;
      do @(posedge clock); while (!req_if.ready);
      if (sb.note_word(func, cx, cy, r))
         useful_words++;
   endtask

   // A step word carries junk in its unused fields. Randomise it so that the
   // block is seen to ignore it.
   task automatic step_once();
      send_word(FUNC_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                RADIUS_BITS'($urandom));
   endtask

   task automatic step_n(int n);
      repeat (n) step_once();
   endtask

   // Mostly whole circles of small radius. Now and then a large radius or an
   // early abandon (a start arriving mid-circle), and stray steps while idle.
   task automatic drive_random_circle();
      logic [RADIUS_BITS-1:0] r;
      int                     steps_left;
      if ($urandom_range(0, 19) == 0)
         step_once();
      r = ($urandom_range(0, 7) == 0) ? RADIUS_BITS'($urandom_range(0, 2047))
                                      : RADIUS_BITS'($urandom_range(0, 24));
      send_word(FUNC_START, COORD_BITS'($urandom), COORD_BITS'($urandom), r);
      if (r > 40)
         steps_left = $urandom_range(1, 6);
      else if ($urandom_range(0, 7) == 0)
         steps_left = $urandom_range(0, 8);
      else
         steps_left = 1 << 20;
      while (sb.running && steps_left > 0) begin
         step_once();
         steps_left--;
      end
      if ($urandom_range(0, 9) == 0)
         step_once();
   endtask

   initial begin
      req_if.valid    = 1'b0;
      req_if.func     = FUNC_STEP;
      req_if.center_x = '0;
      req_if.center_y = '0;
      req_if.radius   = '0;
      reset           = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Directed words, under the first idle pattern.
      step_once();                             // a step straight after reset gives nothing
      send_word(FUNC_START, 12'd2048, 12'd2048, 11'd0);
      step_n(2);                               // zero radius: centre eight times, then idle
      send_word(FUNC_START, 12'd0, 12'd0, 11'd3);
      step_n(3);                               // negative coordinates, diagonal repeats
      send_word(FUNC_START, 12'd4095, 12'd4095, 11'd2047);
      step_n(3);                               // largest coordinates and decision swing
      send_word(FUNC_START, 12'd4095, 12'd0, 11'd1);
      step_n(2);                               // abandon the big circle, finish, step idle
      send_word(FUNC_START, 12'd0, 12'd4095, 11'd2047);
      step_n(2);
      send_word(FUNC_START, 12'd1234, 12'd3000, 11'd5);
      step_once();
      send_word(FUNC_START, 12'd100, 12'd200, 11'd2);
      step_n(2);

      // Random circles. Swap the idle pattern after a third, then drop idling.
      while (useful_words < TOTAL_WORDS) begin
         if (useful_words >= 2 * TOTAL_WORDS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (useful_words >= TOTAL_WORDS / 3) begin
            sender_idle_pct   = 65;
            receiver_idle_pct = 31;
         end
         drive_random_circle();
      end
      @(negedge clock) req_if.valid <= 1'b0;

      // Drain: wait for every expected point, then a little longer to catch strays.
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_points.size() != 0)
         sb.flag_mismatch($sformatf("%0d points never arrived", sb.expected_points.size()));

      if (sb.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
